// ===== sv/mpq_pkg.sv =====
// Shared constants, types and codes for the multilevel priority queue.
package mpq_pkg;

  // Sizing of the queue
  localparam int LEVELS     = 8;
  localparam int POOL_NODES = 64;
  localparam int KEY_BITS   = 32;

  // Port field widths (fixed by the interface)
  localparam int IN_KEY_W = 32;
  localparam int OUT_KEY_W = 32;
  localparam int PRIO_W    = 3;

  // Derived widths
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int NODE_W = $clog2(POOL_NODES);
  localparam int CNT_W  = $clog2(POOL_NODES + 1);

  // Result status codes
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Request action codes
  typedef enum logic {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  // Controller state
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the request and issue the node memory reads
    logic execute;  // update the lists and load the result register
  } mpq_cmd_t;

endpackage

// ===== sv/mpq_if.sv =====
// Valid/ready channel interfaces for requests and results.
interface mpq_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [mpq_pkg::IN_KEY_W-1:0] key;
  logic [mpq_pkg::PRIO_W-1:0]  priority_req;

  modport source (output valid, action, key, priority_req, input ready);
  modport sink   (input valid, action, key, priority_req, output ready);
endinterface

interface mpq_out_if;
  logic                          valid;
  logic                          ready;
  logic [mpq_pkg::OUT_KEY_W-1:0] out_key;
  logic [mpq_pkg::PRIO_W-1:0]    out_priority;
  logic [1:0]                    status;

  modport source (output valid, out_key, out_priority, status, input ready);
  modport sink   (input valid, out_key, out_priority, status, output ready);
endinterface

// ===== sv/mpq_ctrl.sv =====
// Controller: sequences request capture and list update, owns the result beat valid.
module mpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mpq_pkg::mpq_cmd_t cmd
);

  mpq_pkg::state_t state, state_next;
  logic            out_valid_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mpq_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      mpq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = mpq_pkg::S_EXEC;
        end
      end
      mpq_pkg::S_EXEC: begin
        // wait for the result register to be free
        if (!out_valid || out_ready) begin
          cmd.execute = 1'b1;
          state_next  = mpq_pkg::S_IDLE;
        end
      end
      default: state_next = mpq_pkg::S_IDLE;
    endcase
  end

  // Result beat valid: set on update, cleared when taken
  always_comb begin
    out_valid_next = out_valid;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    if (cmd.execute)            out_valid_next = 1'b1;
  end

  a_capture_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == mpq_pkg::S_EXEC)
    else $error("capture not followed by update");

  a_execute_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid)
    else $error("update did not present a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.execute)
    else $error("result overwritten before being taken");

endmodule

// ===== sv/mpq_datapath.sv =====
// Datapath: level head/tail registers, node link and key memories, free list, result register.
module mpq_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  mpq_pkg::mpq_cmd_t             cmd,
  input  logic                          action,
  input  logic [mpq_pkg::IN_KEY_W-1:0]  key,
  input  logic [mpq_pkg::PRIO_W-1:0]    priority_req,
  output logic [mpq_pkg::OUT_KEY_W-1:0] out_key,
  output logic [mpq_pkg::PRIO_W-1:0]    out_priority,
  output logic [1:0]                    status
);

  localparam int LEVELS     = mpq_pkg::LEVELS;
  localparam int POOL_NODES = mpq_pkg::POOL_NODES;
  localparam int KEY_BITS   = mpq_pkg::KEY_BITS;
  localparam int LVL_W      = mpq_pkg::LVL_W;
  localparam int NODE_W     = mpq_pkg::NODE_W;
  localparam int CNT_W      = mpq_pkg::CNT_W;

  // Per-level list state
  logic [NODE_W-1:0] level_head [LEVELS];
  logic [NODE_W-1:0] level_tail [LEVELS];
  logic [LEVELS-1:0] level_nonempty;

  // Node memories
  logic [NODE_W-1:0]   node_link [POOL_NODES];
  logic [KEY_BITS-1:0] node_key  [POOL_NODES];
  logic [NODE_W-1:0]   link_rd;
  logic [KEY_BITS-1:0] key_rd;

  // Free list
  logic [NODE_W-1:0] free_top;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  fresh_mark;

  // Captured request
  logic                op_deq;
  logic [LVL_W-1:0]    op_lvl;
  logic [KEY_BITS-1:0] op_key;
  logic                op_any;

  // Request decode
  logic [LVL_W-1:0]  enq_lvl;
  logic [LVL_W-1:0]  deq_lvl;
  logic              any_nonempty;
  logic [NODE_W-1:0] rd_addr;

  // Update decode
  logic              enq_recycle;
  logic              enq_ok;
  logic [NODE_W-1:0] enq_node;
  logic [NODE_W-1:0] deq_node;
  logic              deq_last;
  logic              link_we;
  logic [NODE_W-1:0] link_waddr;
  logic [NODE_W-1:0] link_wdata;

  // Level selection: saturate enqueue level, lowest nonempty level for dequeue
  always_comb begin
    if (32'(priority_req) >= LEVELS) enq_lvl = LVL_W'(LEVELS - 1);
    else                             enq_lvl = LVL_W'(priority_req);
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (level_nonempty[i]) deq_lvl = LVL_W'(i);
    end
    any_nonempty = |level_nonempty;
    rd_addr      = (action == mpq_pkg::ACT_DEQ) ? level_head[deq_lvl] : free_top;
  end

  // Request register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_deq <= (action == mpq_pkg::ACT_DEQ);
      op_lvl <= (action == mpq_pkg::ACT_DEQ) ? deq_lvl : enq_lvl;
      op_key <= KEY_BITS'(key);
      op_any <= any_nonempty;
    end
  end

  // Update decode for the captured request
  always_comb begin
    enq_recycle = (free_count != '0);
    enq_ok      = enq_recycle || (32'(fresh_mark) < POOL_NODES);
    enq_node    = enq_recycle ? free_top : NODE_W'(fresh_mark);
    deq_node    = level_head[op_lvl];
    deq_last    = (deq_node == level_tail[op_lvl]);
    link_we     = 1'b0;
    link_waddr  = deq_node;
    link_wdata  = '0;
    if (cmd.execute) begin
      if (!op_deq && enq_ok && level_nonempty[op_lvl]) begin
        // append behind the current tail
        link_we    = 1'b1;
        link_waddr = level_tail[op_lvl];
        link_wdata = enq_node;
      end else if (op_deq && op_any) begin
        // push the freed node onto the free list
        link_we    = 1'b1;
        link_waddr = deq_node;
        link_wdata = enq_recycle ? free_top : '0;
      end
    end
  end

  // Node memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (link_we) node_link[link_waddr] <= link_wdata;
    if (cmd.execute && !op_deq && enq_ok) node_key[enq_node] <= op_key;
    if (cmd.capture) begin
      link_rd <= node_link[rd_addr];
      key_rd  <= node_key[rd_addr];
    end
  end

  // Level head and tail
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (!op_deq && enq_ok) begin
        if (!level_nonempty[op_lvl]) level_head[op_lvl] <= enq_node;
        level_tail[op_lvl] <= enq_node;
      end else if (op_deq && op_any && !deq_last) begin
        level_head[op_lvl] <= link_rd;
      end
    end
  end

  // Occupancy and free list
  always_ff @(posedge clk) begin
    if (rst) begin
      level_nonempty <= '0;
      free_top       <= '0;
      free_count     <= '0;
      fresh_mark     <= '0;
    end else if (cmd.execute) begin
      if (!op_deq && enq_ok) begin
        level_nonempty[op_lvl] <= 1'b1;
        if (enq_recycle) begin
          free_top   <= link_rd;
          free_count <= free_count - 1'b1;
        end else begin
          fresh_mark <= fresh_mark + 1'b1;
        end
      end else if (op_deq && op_any) begin
        if (deq_last) level_nonempty[op_lvl] <= 1'b0;
        free_top   <= deq_node;
        free_count <= free_count + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_key      <= '0;
      out_priority <= '0;
      if (op_deq) begin
        if (op_any) begin
          out_key      <= mpq_pkg::OUT_KEY_W'(key_rd);
          out_priority <= mpq_pkg::PRIO_W'(op_lvl);
          status       <= mpq_pkg::ST_DEQ;
        end else begin
          status       <= mpq_pkg::ST_EMPTY;
        end
      end else begin
        status <= enq_ok ? mpq_pkg::ST_ENQ : mpq_pkg::ST_FULL;
      end
    end
  end

  a_free_le_used: assert property (@(posedge clk) disable iff (rst)
    free_count <= fresh_mark)
    else $error("free list holds more nodes than were ever issued");

  a_mark_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fresh_mark) <= POOL_NODES)
    else $error("fresh-node watermark beyond pool");

  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && !op_deq && !enq_ok) |=> $stable(level_nonempty) && $stable(free_count))
    else $error("rejected enqueue changed queue state");

  a_empty_reports: assert property (@(posedge clk) disable iff (rst)
    (cmd.execute && op_deq && !op_any) |=> status == mpq_pkg::ST_EMPTY && out_key == '0)
    else $error("dequeue of empty queue reported wrongly");

endmodule

// ===== sv/multilevel_priority_queue.sv =====
// Multilevel priority queue: eight FIFO levels sharing a 64-node pool. Each request
// (enqueue or dequeue) is handled in two steps: accept it and read the node link and
// key memories at the free-list top or the chosen level's head, then update the lists
// and load the result register, since every operation is a dependent read-modify-write
// of those memories. A new request is accepted while a result waits; the update stalls
// only while the previous result is still untaken.
// Level 0 is served first, an enqueue level above the last is clamped to the last, a
// full pool or empty queue is reported by status and changes nothing. No clearing pass
// is needed after reset.
module multilevel_priority_queue (
  input logic       clk,
  input logic       rst,
  mpq_in_if.sink    in_ch,
  mpq_out_if.source out_ch
);

  mpq_pkg::mpq_cmd_t cmd;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  mpq_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .action       (in_ch.action),
    .key          (in_ch.key),
    .priority_req (in_ch.priority_req),
    .out_key      (out_ch.out_key),
    .out_priority (out_ch.out_priority),
    .status       (out_ch.status)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the multilevel priority queue: scoreboard, drivers, top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  REQ_TARGET = 500;
  localparam time RUN_LIMIT  = 2ms;

  // One result beat as the block should present it
  typedef struct packed {
    logic [mpq_pkg::OUT_KEY_W-1:0] key;
    logic [mpq_pkg::PRIO_W-1:0]    prio;
    mpq_pkg::status_t              status;
  } pq_result_t;

  // Mirror of the level lists and node pool; predicts the result of every request
  class pq_scoreboard;
    logic [mpq_pkg::NODE_W-1:0]   head_node [mpq_pkg::LEVELS];
    logic [mpq_pkg::NODE_W-1:0]   tail_node [mpq_pkg::LEVELS];
    logic [mpq_pkg::NODE_W-1:0]   next_node [mpq_pkg::POOL_NODES];
    logic [mpq_pkg::KEY_BITS-1:0] node_keys [mpq_pkg::POOL_NODES];
    logic [mpq_pkg::LEVELS-1:0]   occupied;
    logic [mpq_pkg::NODE_W-1:0]   recycle_top;
    int                           recycle_count;
    int                           fresh_used;
    pq_result_t                   awaited_results[$];
    int                           failures;

    function new();
      occupied      = '0;
      recycle_top   = '0;
      recycle_count = 0;
      fresh_used    = 0;
      failures      = 0;
    endfunction

    // Enqueue: recycled node first, then a fresh one, else the pool is full
    function pq_result_t push_item(logic [mpq_pkg::IN_KEY_W-1:0] key,
                                   logic [mpq_pkg::PRIO_W-1:0] prio);
      int                         lvl;
      logic [mpq_pkg::NODE_W-1:0] n;
      pq_result_t                 res;
      lvl = int'(prio);
      if (lvl >= mpq_pkg::LEVELS) lvl = mpq_pkg::LEVELS - 1;
      res = '{key: '0, prio: '0, status: mpq_pkg::ST_ENQ};
      if (recycle_count > 0) begin
        n             = recycle_top;
        recycle_top   = next_node[n];
        recycle_count = recycle_count - 1;
      end else if (fresh_used < mpq_pkg::POOL_NODES) begin
        n          = mpq_pkg::NODE_W'(fresh_used);
        fresh_used = fresh_used + 1;
      end else begin
        res.status = mpq_pkg::ST_FULL;
        return res;
      end
      node_keys[n] = key[mpq_pkg::KEY_BITS-1:0];
      next_node[n] = '0;
      if (occupied[lvl]) next_node[tail_node[lvl]] = n;
      else head_node[lvl] = n;
      tail_node[lvl] = n;
      occupied[lvl]  = 1'b1;
      return res;
    endfunction

    // Dequeue: head of the lowest occupied level, node goes back on the free stack
    function pq_result_t pop_item();
      logic [mpq_pkg::NODE_W-1:0] n;
      pq_result_t                 res;
      res = '{key: '0, prio: '0, status: mpq_pkg::ST_EMPTY};
      for (int lvl = 0; lvl < mpq_pkg::LEVELS; lvl++) begin
        if (occupied[lvl]) begin
          n          = head_node[lvl];
          res.key    = mpq_pkg::OUT_KEY_W'(node_keys[n]);
          res.prio   = mpq_pkg::PRIO_W'(lvl);
          res.status = mpq_pkg::ST_DEQ;
          if (n == tail_node[lvl]) occupied[lvl] = 1'b0;
          else head_node[lvl] = next_node[n];
          next_node[n]  = (recycle_count > 0) ? recycle_top : '0;
          recycle_top   = n;
          recycle_count = recycle_count + 1;
          return res;
        end
      end
      return res;
    endfunction

    function void note_request(mpq_pkg::action_t act, logic [mpq_pkg::IN_KEY_W-1:0] key,
                               logic [mpq_pkg::PRIO_W-1:0] prio);
      if (act == mpq_pkg::ACT_ENQ) awaited_results.push_back(push_item(key, prio));
      else awaited_results.push_back(pop_item());
    endfunction

    function void check_result(logic [mpq_pkg::OUT_KEY_W-1:0] key,
                               logic [mpq_pkg::PRIO_W-1:0] prio,
                               logic [1:0] status);
      pq_result_t exp_res;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing outstanding: key %h prio %0d status %0d",
               key, prio, status);
        failures++;
        return;
      end
      exp_res = awaited_results.pop_front();
      if (status !== exp_res.status) begin
        $error("status mismatch: expected %0d, got %0d", exp_res.status, status);
        failures++;
      end
      if (key !== exp_res.key) begin
        $error("out_key mismatch: expected %h, got %h", exp_res.key, key);
        failures++;
      end
      if (prio !== exp_res.prio) begin
        $error("out_priority mismatch: expected %0d, got %0d", exp_res.prio, prio);
        failures++;
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic         clk;
  logic         rst;
  mpq_in_if     in_ch ();
  mpq_out_if    out_ch ();
  pq_scoreboard sb;
  bit           src_steady;
  int           sent;

  multilevel_priority_queue u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  // Drive one request beat; entered and left just after a falling edge
  task automatic drive_request(mpq_pkg::action_t act, logic [mpq_pkg::IN_KEY_W-1:0] key,
                               logic [mpq_pkg::PRIO_W-1:0] prio);
    int gap;
    gap = pick_gap(src_steady);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.action       = act;
    in_ch.key          = key;
    in_ch.priority_req = prio;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(act, key, prio);
    sent++;
    @(negedge clk);
  endtask

  task automatic enqueue(logic [mpq_pkg::IN_KEY_W-1:0] key, logic [mpq_pkg::PRIO_W-1:0] prio);
    drive_request(mpq_pkg::ACT_ENQ, key, prio);
  endtask

  // Key and priority lines carry noise on a dequeue
  task automatic dequeue();
    drive_request(mpq_pkg::ACT_DEQ, $urandom, mpq_pkg::PRIO_W'($urandom));
  endtask

  // Random key, leaning on the all-zero and all-one corners now and then
  function automatic logic [mpq_pkg::IN_KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Result side: accept beats with random stalls
  initial begin
    int stall;
    int beats;
    bit steady;
    stall        = 0;
    beats        = 0;
    steady       = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        stall--;
      end else begin
        out_ch.ready = 1'b1;
      end
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.out_key, out_ch.out_priority, out_ch.status);
        beats++;
        if (beats % 40 == 0) steady = ($urandom_range(0, 2) == 0);
        stall = pick_gap(steady);
      end
      @(negedge clk);
    end
  end

  // Stimulus and end of run
  initial begin
    int enq_pct;
    int burst_len;
    int hot_level;
    sb                 = new();
    sent               = 0;
    src_steady         = 1'b0;
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.action       = mpq_pkg::ACT_ENQ;
    in_ch.key          = '0;
    in_ch.priority_req = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty queue, every level, key extremes, FIFO order within a level
    dequeue();
    enqueue('1, 3'd7);
    enqueue('0, 3'd0);
    enqueue(32'hA5A5_A5A5, 3'd3);
    enqueue(32'h5A5A_5A5A, 3'd3);
    enqueue(32'h0000_0001, 3'd0);
    enqueue(32'h8000_0000, 3'd1);
    enqueue(32'h1234_5678, 3'd2);
    enqueue(32'h7FFF_FFFF, 3'd4);
    enqueue(32'hDEAD_BEEF, 3'd5);
    enqueue(32'hCAFE_F00D, 3'd6);
    repeat (11) dequeue();

    // Random bursts: fill to a full pool, drain to empty, and mixed traffic between
    while (sent < REQ_TARGET) begin
      case ($urandom_range(0, 5))
        0:       enq_pct = 100;
        1:       enq_pct = 90;
        2:       enq_pct = 60;
        3:       enq_pct = 50;
        4:       enq_pct = 25;
        default: enq_pct = 0;
      endcase
      burst_len  = $urandom_range(20, 80);
      src_steady = ($urandom_range(0, 3) == 0);
      hot_level  = $urandom_range(0, mpq_pkg::LEVELS - 1);
      repeat (burst_len) begin
        if ($urandom_range(0, 99) < enq_pct) begin
          // about a third of the enqueues pile onto the burst's hot level to build long lists
          if ($urandom_range(0, 2) == 0) enqueue(pick_key(), mpq_pkg::PRIO_W'(hot_level));
          else enqueue(pick_key(), mpq_pkg::PRIO_W'($urandom_range(0, 7)));
        end else begin
          dequeue();
        end
      end
    end
    in_ch.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mpq_pkg.sv
sv/mpq_if.sv
sv/mpq_ctrl.sv
sv/mpq_datapath.sv
sv/multilevel_priority_queue.sv
sim/tb_top.sv
